[rtl/ffha_pkg.sv]
// Shared types, constants and status codes of the first-fit heap allocator.
package ffha_pkg;

	localparam int MAX_SEGMENTS = 32;
	localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = SEG_IDX_W + 1;
	localparam int ARENA_BITS = 20;
	localparam int LEN_W = ARENA_BITS + 1;
	localparam int SUM_W = LEN_W + 1;
	localparam int HEADER_SIZE = 16;
	localparam logic [LEN_W-1:0] ARENA_RESET = LEN_W'(1048576);
	localparam logic [LEN_W-1:0] ARENA_LIMIT = LEN_W'(1) << ARENA_BITS;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic                  cmd;
		logic [LEN_W-1:0]      req_size;
		logic [ARENA_BITS-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ARENA_BITS-1:0] result_address;
		logic [1:0]            status;
	} rsp_t;

	// One table entry: header offset, payload length and free mark.
	typedef struct packed {
		logic [ARENA_BITS-1:0] off;
		logic [LEN_W-1:0]      len;
		logic                  free;
	} seg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] diff;
		logic             ge;
		logic             gt;
	} alu_t;

endpackage

[rtl/ffha_seg_ram.sv]
// Segment table memory: one write port and one registered read port.
module ffha_seg_ram
	import ffha_pkg::*;
(
	input  logic                 clk,
	input  logic                 we,
	input  logic [SEG_IDX_W-1:0] wa,
	input  seg_t                 wd,
	input  logic [SEG_IDX_W-1:0] ra,
	output seg_t                 rd
);

	seg_t mem [MAX_SEGMENTS];
	seg_t rd_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

[rtl/ffha_alu.sv]
// Shared adder and comparator for sizes, offsets and header arithmetic.
module ffha_alu
	import ffha_pkg::*;
(
	input  logic [LEN_W-1:0] a,
	input  logic [LEN_W-1:0] b,
	output alu_t             res
);

	logic [SUM_W-1:0] b_hdr;

	// The header size is added to b once and reused by the sum, difference and greater-than results.
	always_comb begin
		b_hdr = SUM_W'(b) + SUM_W'(HEADER_SIZE);
		res.sum = SUM_W'(a) + b_hdr;
		res.diff = LEN_W'(SUM_W'(a) - b_hdr);
		res.ge = (a >= b);
		res.gt = (SUM_W'(a) > b_hdr);
	end

endmodule

[rtl/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator: sequencer, table memory and ALU.
//
// Input channel in_valid/in_ready/in_data carries one request: allocate
// (cmd 0, req_size) or free (cmd 1, block_address). Every request gives
// exactly one result on out_valid/out_ready/out_data: a payload offset and
// a status. A configuration transfer on cfg_valid/cfg_ready/cfg_data sets
// the arena size and rebuilds the table as one free segment.
// One request is handled at a time. The sequencer walks the segment table
// through a memory with a registered read port, with a read state and a
// check state for each entry visited in a first-fit search. A split moves
// entries up one by one (A_SHR, A_SHW), and each merge on free moves
// entries down one by one (D_RD, D_WR). After reset, and after each
// configuration transfer, the initial segment is written in the idle state
// before the next request is taken. A result waits in the output register
// while the receiver stalls; the next request is accepted meanwhile, but
// its result is held in the sequencer until the output register has been
// emptied.
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] A_RD = 4'd1;
	localparam logic [3:0] A_CHK = 4'd2;
	localparam logic [3:0] A_SHR = 4'd3;
	localparam logic [3:0] A_SHW = 4'd4;
	localparam logic [3:0] A_SPL = 4'd5;
	localparam logic [3:0] A_TAKE = 4'd6;
	localparam logic [3:0] F_RD = 4'd7;
	localparam logic [3:0] F_CHK = 4'd8;
	localparam logic [3:0] F_L = 4'd9;
	localparam logic [3:0] F_LC = 4'd10;
	localparam logic [3:0] F_R = 4'd11;
	localparam logic [3:0] F_RC = 4'd12;
	localparam logic [3:0] D_RD = 4'd13;
	localparam logic [3:0] D_WR = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      k_q;
	logic [LEN_W-1:0]      size_q;
	logic [ARENA_BITS-1:0] addr_q;
	logic [LEN_W-1:0]      rem_q;
	logic [LEN_W-1:0]      arena_q;
	logic                  pend_q;
	logic                  split_q;
	logic                  ret_left_q;
	seg_t                  cur_q;
	rsp_t                  res_q;
	logic                  out_valid_q;
	rsp_t                  out_data_q;

	logic                  we;
	logic [SEG_IDX_W-1:0]  wa;
	seg_t                  wd;
	logic [SEG_IDX_W-1:0]  ra;
	seg_t                  rd;
	logic [LEN_W-1:0]      alu_a;
	logic [LEN_W-1:0]      alu_b;
	alu_t                  alu;
	logic [LEN_W-1:0]      arena_sat;
	logic [LEN_W-1:0]      len0;
	logic [CNT_W-1:0]      idx_m1;
	logic [CNT_W-1:0]      idx_p1;
	logic [CNT_W-1:0]      k_m1;
	logic [CNT_W-1:0]      k_p1;
	logic                  cfg_fire;
	logic                  in_fire;
	logic                  addr_hit;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid & cfg_ready;
	assign in_ready = (state_q == S_IDLE) & ~pend_q;
	assign in_fire = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign idx_m1 = idx_q - CNT_W'(1);
	assign idx_p1 = idx_q + CNT_W'(1);
	assign k_m1 = k_q - CNT_W'(1);
	assign k_p1 = k_q + CNT_W'(1);
	assign addr_hit = (alu.sum == SUM_W'(addr_q));

	// Initial payload length of a rebuilt table, with the arena saturated.
	always_comb begin
		arena_sat = (arena_q > ARENA_LIMIT) ? ARENA_LIMIT : arena_q;
		len0 = (arena_sat > LEN_W'(HEADER_SIZE)) ? arena_sat - LEN_W'(HEADER_SIZE) : '0;
	end

	ffha_seg_ram u_ram (
		.clk (clk),
		.we  (we),
		.wa  (wa),
		.wd  (wd),
		.ra  (ra),
		.rd  (rd)
	);

	ffha_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	// Memory port and ALU operand selection for each sequencer step.
	always_comb begin
		ra = idx_q[SEG_IDX_W-1:0];
		we = 1'b0;
		wa = idx_q[SEG_IDX_W-1:0];
		wd = cur_q;
		alu_a = cur_q.len;
		alu_b = '0;
		case (state_q)
			S_IDLE: begin
				we = pend_q;
				wa = '0;
				wd = '{off: '0, len: len0, free: 1'b1};
			end
			A_CHK: begin
				alu_a = rd.len;
				alu_b = size_q;
			end
			A_SHR: begin
				ra = k_m1[SEG_IDX_W-1:0];
			end
			A_SHW: begin
				we = 1'b1;
				wa = k_q[SEG_IDX_W-1:0];
				wd = rd;
			end
			A_SPL: begin
				alu_a = LEN_W'(cur_q.off);
				alu_b = size_q;
				we = 1'b1;
				wa = idx_p1[SEG_IDX_W-1:0];
				wd = '{off: alu.sum[ARENA_BITS-1:0], len: rem_q, free: 1'b1};
			end
			A_TAKE: begin
				alu_a = LEN_W'(cur_q.off);
				we = 1'b1;
				wd = '{off: cur_q.off, len: (split_q ? size_q : cur_q.len), free: 1'b0};
			end
			F_CHK: begin
				alu_a = LEN_W'(rd.off);
				we = ~rd.free & addr_hit;
				wd = '{off: rd.off, len: rd.len, free: 1'b1};
			end
			F_L: begin
				ra = idx_m1[SEG_IDX_W-1:0];
			end
			F_LC: begin
				alu_a = rd.len;
				alu_b = cur_q.len;
				we = rd.free;
				wa = idx_m1[SEG_IDX_W-1:0];
				wd = '{off: rd.off, len: alu.sum[LEN_W-1:0], free: 1'b1};
			end
			F_R: begin
				ra = idx_p1[SEG_IDX_W-1:0];
			end
			F_RC: begin
				alu_a = cur_q.len;
				alu_b = rd.len;
				we = rd.free;
				wd = '{off: cur_q.off, len: alu.sum[LEN_W-1:0], free: 1'b1};
			end
			D_RD: begin
				ra = k_p1[SEG_IDX_W-1:0];
			end
			D_WR: begin
				we = 1'b1;
				wa = k_q[SEG_IDX_W-1:0];
				wd = rd;
			end
			default: begin
			end
		endcase
	end

	// Sequencer for search, split, merge and table moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= CNT_W'(1);
			idx_q <= '0;
			k_q <= '0;
			arena_q <= ARENA_RESET;
			pend_q <= 1'b1;
			split_q <= 1'b0;
			ret_left_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				arena_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						cnt_q <= CNT_W'(1);
					end else if (in_fire) begin
						size_q <= in_data.req_size;
						addr_q <= in_data.block_address;
						idx_q <= '0;
						if (in_data.cmd == CMD_FREE) begin
							state_q <= F_RD;
						end else if (in_data.req_size == '0) begin
							res_q <= '{result_address: '0, status: ST_FAIL};
							state_q <= S_DONE;
						end else begin
							state_q <= A_RD;
						end
					end
				end
				A_RD: begin
					if (idx_q >= cnt_q) begin
						res_q <= '{result_address: '0, status: ST_FAIL};
						state_q <= S_DONE;
					end else begin
						state_q <= A_CHK;
					end
				end
				A_CHK: begin
					if (rd.free && alu.ge) begin
						cur_q <= rd;
						rem_q <= alu.diff;
						if (alu.gt && cnt_q != CNT_W'(MAX_SEGMENTS)) begin
							split_q <= 1'b1;
							k_q <= cnt_q;
							state_q <= A_SHR;
						end else begin
							split_q <= 1'b0;
							state_q <= A_TAKE;
						end
					end else begin
						idx_q <= idx_p1;
						state_q <= A_RD;
					end
				end
				A_SHR: begin
					state_q <= (k_q > idx_p1) ? A_SHW : A_SPL;
				end
				A_SHW: begin
					k_q <= k_m1;
					state_q <= A_SHR;
				end
				A_SPL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					state_q <= A_TAKE;
				end
				A_TAKE: begin
					res_q <= '{result_address: alu.sum[ARENA_BITS-1:0], status: ST_ALLOC};
					state_q <= S_DONE;
				end
				F_RD: begin
					if (idx_q >= cnt_q) begin
						res_q <= '{result_address: '0, status: ST_IGNORED};
						state_q <= S_DONE;
					end else begin
						state_q <= F_CHK;
					end
				end
				F_CHK: begin
					if (!rd.free && addr_hit) begin
						cur_q <= '{off: rd.off, len: rd.len, free: 1'b1};
						state_q <= F_L;
					end else begin
						idx_q <= idx_p1;
						state_q <= F_RD;
					end
				end
				F_L: begin
					state_q <= (idx_q != '0) ? F_LC : F_R;
				end
				F_LC: begin
					if (rd.free) begin
						cur_q <= '{off: rd.off, len: alu.sum[LEN_W-1:0], free: 1'b1};
						k_q <= idx_q;
						idx_q <= idx_m1;
						ret_left_q <= 1'b1;
						state_q <= D_RD;
					end else begin
						state_q <= F_R;
					end
				end
				F_R: begin
					if (idx_p1 < cnt_q) begin
						state_q <= F_RC;
					end else begin
						res_q <= '{result_address: '0, status: ST_FREED};
						state_q <= S_DONE;
					end
				end
				F_RC: begin
					if (rd.free) begin
						cur_q.len <= alu.sum[LEN_W-1:0];
						k_q <= idx_p1;
						ret_left_q <= 1'b0;
						state_q <= D_RD;
					end else begin
						res_q <= '{result_address: '0, status: ST_FREED};
						state_q <= S_DONE;
					end
				end
				D_RD: begin
					if (k_p1 < cnt_q) begin
						state_q <= D_WR;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
						state_q <= ret_left_q ? F_L : F_R;
					end
				end
				D_WR: begin
					k_q <= k_p1;
					state_q <= D_RD;
				end
				S_DONE: begin
					if (!out_valid_q) begin
						out_data_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A configuration transfer schedules a rebuild; it wins over the clear.
			if (cfg_fire) begin
				pend_q <= 1'b1;
			end else if (state_q == S_IDLE) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

[sim/tb.sv]
// Self-checking testbench of the first-fit heap allocator.
`timescale 1ns / 1ps

module tb;
	import ffha_pkg::*;

	// A free request with this size field is aimed at a live block when it is sent.
	localparam logic [LEN_W-1:0] LIVE_MARK = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the segment table.
	logic [ARENA_BITS-1:0] shadow_off [MAX_SEGMENTS];
	logic [LEN_W-1:0] shadow_len [MAX_SEGMENTS];
	logic shadow_free [MAX_SEGMENTS];
	int shadow_count;
	logic [ARENA_BITS-1:0] live_addrs [$];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int mismatches = 0;
	int hold_cycles = 0;
	logic hold_start = 1'b0;
	logic hold_done = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	// Rebuild the table as a single free segment.
	function automatic void rebuild_shadow(logic [LEN_W-1:0] size);
		longint sz;
		sz = longint'(size);
		if (sz > (longint'(1) << ARENA_BITS))
			sz = longint'(1) << ARENA_BITS;
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			shadow_off[k] = '0;
			shadow_len[k] = '0;
			shadow_free[k] = 1'b0;
		end
		shadow_len[0] = (sz > HEADER_SIZE) ? LEN_W'(sz - HEADER_SIZE) : '0;
		shadow_free[0] = 1'b1;
		shadow_count = 1;
		live_addrs.delete();
	endfunction

	function automatic void absorb_next(int idx);
		shadow_len[idx] = LEN_W'(shadow_len[idx] + HEADER_SIZE + shadow_len[idx+1]);
		for (int k = idx + 1; k + 1 < shadow_count; k++) begin
			shadow_off[k] = shadow_off[k+1];
			shadow_len[k] = shadow_len[k+1];
			shadow_free[k] = shadow_free[k+1];
		end
		shadow_count--;
		shadow_off[shadow_count] = '0;
		shadow_len[shadow_count] = '0;
		shadow_free[shadow_count] = 1'b0;
	endfunction

	// Compute the response of one request and update the shadow table.
	function automatic rsp_t predict_heap(req_t r);
		rsp_t rsp;
		int i;
		longint sz;
		rsp = '0;
		if (r.cmd == CMD_ALLOC) begin
			sz = longint'(r.req_size);
			rsp.status = ST_FAIL;
			if (sz != 0) begin
				for (i = 0; i < shadow_count; i++)
					if (shadow_free[i] && shadow_len[i] >= sz) break;
				if (i < shadow_count) begin
					if (longint'(shadow_len[i]) > sz + HEADER_SIZE &&
							shadow_count < MAX_SEGMENTS) begin
						for (int k = shadow_count; k > i + 1; k--) begin
							shadow_off[k] = shadow_off[k-1];
							shadow_len[k] = shadow_len[k-1];
							shadow_free[k] = shadow_free[k-1];
						end
						shadow_off[i+1] = ARENA_BITS'(shadow_off[i] + HEADER_SIZE + sz);
						shadow_len[i+1] = LEN_W'(shadow_len[i] - (sz + HEADER_SIZE));
						shadow_free[i+1] = 1'b1;
						shadow_len[i] = LEN_W'(sz);
						shadow_count++;
					end
					shadow_free[i] = 1'b0;
					rsp.result_address = ARENA_BITS'(shadow_off[i] + HEADER_SIZE);
					rsp.status = ST_ALLOC;
					live_addrs.push_back(rsp.result_address);
				end
			end
		end else begin
			rsp.status = ST_IGNORED;
			for (i = 0; i < shadow_count; i++)
				if (!shadow_free[i] &&
						longint'(shadow_off[i]) + HEADER_SIZE == longint'(r.block_address))
					break;
			if (i < shadow_count) begin
				rsp.status = ST_FREED;
				shadow_free[i] = 1'b1;
				while (i > 0 && shadow_free[i-1]) begin
					absorb_next(i - 1);
					i--;
				end
				while (i + 1 < shadow_count && shadow_free[i+1])
					absorb_next(i);
			end
		end
		return rsp;
	endfunction

	function automatic req_t make_alloc(int unsigned sz);
		req_t r;
		r = '0;
		r.cmd = CMD_ALLOC;
		r.req_size = LEN_W'(sz);
		r.block_address = ARENA_BITS'($urandom);
		return r;
	endfunction

	function automatic req_t make_free(int unsigned a);
		req_t r;
		r = '0;
		r.cmd = CMD_FREE;
		r.req_size = LEN_W'($urandom_range(0, (1 << LEN_W) - 2));
		r.block_address = ARENA_BITS'(a);
		return r;
	endfunction

	// A free whose address is picked among the live blocks when it is sent.
	function automatic req_t make_live_free();
		req_t r;
		r = '0;
		r.cmd = CMD_FREE;
		r.req_size = LIVE_MARK;
		return r;
	endfunction

	// Fill in the address of a live-block free from the current prediction.
	function automatic req_t resolve_req(req_t r);
		req_t q;
		int unsigned idx;
		q = r;
		if (q.cmd == CMD_FREE && q.req_size == LIVE_MARK) begin
			q.req_size = '0;
			if (live_addrs.size() > 0) begin
				idx = $urandom_range(0, live_addrs.size() - 1);
				q.block_address = live_addrs[idx];
			end else
				q.block_address = ARENA_BITS'($urandom);
		end
		return q;
	endfunction

	// Random request: mostly frees of live blocks and small allocations.
	function automatic req_t random_req();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return make_live_free();
		else if (pick < 48)
			return make_free($urandom);
		else if (pick < 52)
			return make_alloc($urandom_range(0, 2097151));
		else if (pick < 55)
			return make_alloc(0);
		return make_alloc($urandom_range(1, 4096));
	endfunction

	// Driver: offers queued requests with random gaps.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_rsps.push_back(predict_heap(in_data));
			send_gap <= $urandom_range(0, 10);
			if (pending_reqs.size() > 0 && $urandom_range(0, 10) == 0) begin
				in_data <= resolve_req(pending_reqs.pop_front());
			end else
				in_valid <= 1'b0;
		end else if (!in_valid && arst_n) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if (pending_reqs.size() > 0) begin
				in_data <= resolve_req(pending_reqs.pop_front());
				in_valid <= 1'b1;
			end
		end
	end

	// Long receiver stall, counted once after it is requested.
	always @(posedge clk) begin
		if (hold_start && !hold_done) begin
			hold_cycles <= 3000;
			hold_done <= 1'b1;
		end else if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	// Monitor: compares each response transfer with the oldest expectation.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response addr=%0d status=%0d",
						out_data.result_address, out_data.status);
			end else begin
				rsp_t want;
				want = expected_rsps.pop_front();
				if (want !== out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
							want.result_address, want.status,
							out_data.result_address, out_data.status);
				end
			end
			recv_gap <= $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
		end else if (!out_ready) begin
			if (recv_gap > 0)
				recv_gap <= recv_gap - 1;
			else
				out_ready <= 1'b1;
		end
	end

	task automatic drain_and_settle();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_arena(logic [LEN_W-1:0] size);
		cfg_data <= size;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rebuild_shadow(size);
	endtask

	initial begin
		logic [LEN_W-1:0] arenas [6];
		rebuild_shadow(ARENA_RESET);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero request, no fit, bad frees.
		pending_reqs.push_back(make_alloc(0));
		pending_reqs.push_back(make_alloc(2097151));
		pending_reqs.push_back(make_alloc(1048560));
		pending_reqs.push_back(make_free(16));
		pending_reqs.push_back(make_free(16));
		pending_reqs.push_back(make_free(1048575));
		pending_reqs.push_back(make_free(0));
		pending_reqs.push_back(make_alloc(1));
		pending_reqs.push_back(make_alloc(100));
		pending_reqs.push_back(make_free(16));
		pending_reqs.push_back(make_free(33));
		pending_reqs.push_back(make_alloc(1048575));
		drain_and_settle();

		// Table full: many tiny allocations in a small arena.
		write_arena(LEN_W'(2048));
		for (int k = 0; k < 36; k++)
			pending_reqs.push_back(make_alloc(8));
		drain_and_settle();

		// Tiny and oversized arenas.
		write_arena(LEN_W'(16));
		pending_reqs.push_back(make_alloc(1));
		drain_and_settle();
		write_arena(LEN_W'(2097151));
		pending_reqs.push_back(make_alloc(1048560));
		pending_reqs.push_back(make_free(16));
		drain_and_settle();

		// Random phases over several arena sizes; one long receiver stall.
		arenas = '{LEN_W'(64), LEN_W'(1048576), LEN_W'(8192), LEN_W'(0),
			LEN_W'(65536), LEN_W'(2097151)};
		for (int p = 0; p < 6; p++) begin
			write_arena(arenas[p]);
			if (p == 1)
				hold_start <= 1'b1;
			for (int k = 0; k < 145; k++)
				pending_reqs.push_back(random_req());
			drain_and_settle();
		end

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

endmodule
